FILE: rtl/wbss_pkg.sv
// Shared types and constants for the wildcard byte signature search block.
package wbss_pkg;

   localparam int ADDR_BITS      = 64;
   localparam int SIG_WORD_BITS  = 64;
   localparam int CARE_BITS      = 16;
   localparam int LEN_BITS       = 5;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIG_BYTES_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIG_BYTES_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARE_MASK      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIG_LENGTH     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_BASE    = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] match_address;
   } rsp_type;

   typedef struct packed {
      logic [SIG_WORD_BITS-1:0] sig_bytes_low;
      logic [SIG_WORD_BITS-1:0] sig_bytes_high;
      logic [CARE_BITS-1:0]     care_mask;
      logic [LEN_BITS-1:0]      sig_length;
      logic [ADDR_BITS-1:0]     region_base;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

endpackage

FILE: rtl/wbss_csr.sv
// Configuration registers of the signature search.
module wbss_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [wbss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wbss_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output wbss_pkg::cfg_type                     cfg
);
   import wbss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SIG_BYTES_LOW:  cfg_in.sig_bytes_low  = csr_write_data;
            CSR_SIG_BYTES_HIGH: cfg_in.sig_bytes_high = csr_write_data;
            CSR_CARE_MASK:      cfg_in.care_mask      = csr_write_data[CARE_BITS-1:0];
            CSR_SIG_LENGTH:     cfg_in.sig_length     = csr_write_data[LEN_BITS-1:0];
            CSR_REGION_BASE:    cfg_in.region_base    = csr_write_data[ADDR_BITS-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/wbss_match.sv
// Masked parallel compare of the signature against the newest bytes.
module wbss_match #(
   parameter int MAX_SIG_BYTES = 16,
   parameter int WIN_DEPTH     = 15,
   parameter int COUNT_BITS    = 32
) (
   input  wbss_pkg::cfg_type        cfg,
   input  logic [7:0]               cur_byte,
   input  logic [7:0]               window [WIN_DEPTH],
   input  logic [COUNT_BITS-1:0]    have,
   output logic                     hit,
   output logic [wbss_pkg::ADDR_BITS-1:0] address
);
   import wbss_pkg::*;

   localparam int IDX_BITS = (MAX_SIG_BYTES > 1) ? $clog2(MAX_SIG_BYTES) : 1;
   localparam int HIST     = 1 << IDX_BITS;

   logic [7:0]                 hist [HIST];
   logic [2*SIG_WORD_BITS-1:0] sig_all;
   logic [MAX_SIG_BYTES-1:0]   byte_ok;
   logic                       len_ok;
   logic [COUNT_BITS-1:0]      len_wide;
   logic [COUNT_BITS-1:0]      offset;

   assign sig_all  = {cfg.sig_bytes_high, cfg.sig_bytes_low};
   assign len_wide = {{(COUNT_BITS-LEN_BITS){1'b0}}, cfg.sig_length};

   // Entry 0 is the byte being taken now, entry k the byte k places older.
   genvar k;
   generate
      for (k = 0; k < HIST; k++) begin : g_hist
         if (k == 0) begin : g_cur
            assign hist[k] = cur_byte;
         end else if (k - 1 < WIN_DEPTH) begin : g_win
            assign hist[k] = window[k-1];
         end else begin : g_pad
            assign hist[k] = 8'h00;
         end
      end
   endgenerate

   always_comb begin
      logic [LEN_BITS-1:0] back;
      for (int j = 0; j < MAX_SIG_BYTES; j++) begin
         back = cfg.sig_length - LEN_BITS'(j + 1);
         byte_ok[j] = (LEN_BITS'(j) >= cfg.sig_length) || !cfg.care_mask[j] ||
                      (hist[back[IDX_BITS-1:0]] == sig_all[8*j +: 8]);
      end
   end

   assign len_ok = (cfg.sig_length != '0) &&
                   (cfg.sig_length <= LEN_BITS'(MAX_SIG_BYTES));
   assign hit    = len_ok && (have >= len_wide) && (&byte_ok);
   assign offset = have - len_wide;
   assign address = cfg.region_base + {{(ADDR_BITS-COUNT_BITS){1'b0}}, offset};

endmodule

FILE: rtl/wbss_scan.sv
// Input register, byte window, byte count and per-region match state.
module wbss_scan #(
   parameter int MAX_SIG_BYTES = 16,
   parameter int COUNT_BITS    = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  wbss_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  wbss_pkg::req_type   req_payload,
   input  logic                buf_full,
   output wbss_pkg::push_type  push
);
   import wbss_pkg::*;

   localparam int WIN_DEPTH = (MAX_SIG_BYTES > 1) ? MAX_SIG_BYTES - 1 : 1;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   req_type               in_req_ff;
   logic [7:0]            window_ff [WIN_DEPTH];
   logic [7:0]            window_in [WIN_DEPTH];
   logic [COUNT_BITS-1:0] seen_ff;
   logic [COUNT_BITS-1:0] seen_in;
   logic                  done_ff;
   logic                  done_in;
   logic [COUNT_BITS-1:0] have;
   logic                  accept;
   logic                  take;
   logic                  hit_raw;
   logic                  hit;
   logic [ADDR_BITS-1:0]  address;

   assign req_stall = in_valid_ff && buf_full;
   assign accept    = req_valid && !req_stall;
   assign take      = in_valid_ff && !buf_full;
   assign have      = (&seen_ff) ? seen_ff : seen_ff + COUNT_BITS'(1);

   wbss_match #(
      .MAX_SIG_BYTES (MAX_SIG_BYTES),
      .WIN_DEPTH     (WIN_DEPTH),
      .COUNT_BITS    (COUNT_BITS)
   ) u_match (
      .cfg      (cfg),
      .cur_byte (in_req_ff.data_byte),
      .window   (window_ff),
      .have     (have),
      .hit      (hit_raw),
      .address  (address)
   );

   assign hit = hit_raw && !done_ff;

   always_comb begin
      push.valid              = take && (hit || (in_req_ff.last_byte && !done_ff));
      push.data.found         = hit;
      push.data.match_address = hit ? address : '0;
   end

   always_comb begin
      in_valid_in = accept ? 1'b1 : (take ? 1'b0 : in_valid_ff);
      window_in   = window_ff;
      seen_in     = seen_ff;
      done_in     = done_ff;
      if (take) begin
         if (in_req_ff.last_byte) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
               window_in[i] = 8'h00;
            end
            seen_in = '0;
            done_in = 1'b0;
         end else begin
            window_in[0] = in_req_ff.data_byte;
            for (int i = 1; i < WIN_DEPTH; i++) begin
               window_in[i] = window_ff[i-1];
            end
            seen_in = have;
            done_in = done_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         seen_ff     <= '0;
         done_ff     <= 1'b0;
         for (int i = 0; i < WIN_DEPTH; i++) begin
            window_ff[i] <= 8'h00;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         seen_ff     <= seen_in;
         done_ff     <= done_in;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_req_ff <= req_payload;
      end
   end

endmodule

FILE: rtl/wbss_obuf.sv
// Result register with a skid stage behind it.
module wbss_obuf (
   input  logic                clock,
   input  logic                reset,
   input  wbss_pkg::push_type  push,
   output logic                buf_full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wbss_pkg::rsp_type   rsp_payload
);
   import wbss_pkg::*;

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = push.data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push.data;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign buf_full    = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

FILE: rtl/wildcard_byte_signature_search_top.sv
// Top level of the wildcard byte signature search.
// A request is registered at acceptance; its result, if any, is registered in the result register
// when the input register passes it on, or in the skid stage while the result register is held.
// One request is accepted every cycle while req_stall is low; the skid stage behind the
// result register absorbs one result while the response side stalls.
// Synchronous reset clears the configuration, the byte window, the count and all valid flags.
module wildcard_byte_signature_search_top #(
   parameter int MAX_SIG_BYTES = 16,
   parameter int COUNT_BITS    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wbss_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wbss_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [wbss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wbss_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import wbss_pkg::*;

   cfg_type  cfg;
   push_type push;
   logic     buf_full;

   wbss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wbss_scan #(
      .MAX_SIG_BYTES (MAX_SIG_BYTES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .buf_full    (buf_full),
      .push        (push)
   );

   wbss_obuf u_obuf (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .buf_full    (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: test/tb_wildcard_byte_signature_search_top.sv
// Self-checking testbench for the wildcard byte signature search top level.
`timescale 1ns / 100ps

module tb_wildcard_byte_signature_search_top;
   import wbss_pkg::*;

   localparam int WINDOW_DEPTH = 15;
   localparam int SIG_MAX      = 16;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_SIG_BYTES_LOW;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   cfg_type     search_cfg = '0;
   logic [7:0]  recent_bytes [0:WINDOW_DEPTH-1];
   logic [31:0] region_count = '0;
   bit          region_matched = 1'b0;
   rsp_type     expected_results [$];
   int          mismatch_count = 0;
   bit          calm = 1'b0;

   wildcard_byte_signature_search_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_wildcard_byte_signature_search_top failed");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch in %s: expected %h, got %h", what, want, got);
      end
   endtask

   function automatic logic [7:0] signature_byte(input int j);
      logic [127:0] sig_all;
      sig_all = {search_cfg.sig_bytes_high, search_cfg.sig_bytes_low};
      return sig_all[8*j +: 8];
   endfunction

   function automatic void queue_expected(input rsp_type result);
      expected_results.insert(expected_results.size(), result);
   endfunction

   function automatic void predict_search_step(input req_type item);
      logic [31:0] have;
      int          len;
      int          back;
      bit          hit;
      logic [7:0]  b;
      rsp_type     result;
      have = (region_count == '1) ? region_count : region_count + 1;
      len = int'(search_cfg.sig_length);
      if (!region_matched && len >= 1 && len <= SIG_MAX && have >= len) begin
         hit = 1'b1;
         for (int j = 0; j < len; j++) begin
            back = len - 1 - j;
            b = (back == 0) ? item.data_byte : recent_bytes[back-1];
            if (search_cfg.care_mask[j] && b != signature_byte(j)) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            region_matched = 1'b1;
            result.found = 1'b1;
            result.match_address = search_cfg.region_base + 64'(have - len);
            queue_expected(result);
         end
      end
      if (item.last_byte) begin
         if (!region_matched) begin
            result = '0;
            queue_expected(result);
         end
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            recent_bytes[k] = 8'h00;
         end
         region_count = '0;
         region_matched = 1'b0;
      end else begin
         for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
            recent_bytes[k] = recent_bytes[k-1];
         end
         recent_bytes[0] = item.data_byte;
         region_count = have;
      end
   endfunction

   always @(negedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 8);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            note_mismatch("unexpected result", '0, {63'd0, rsp_payload.found});
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.found !== want.found) begin
               note_mismatch("found", {63'd0, want.found}, {63'd0, rsp_payload.found});
            end
            if (rsp_payload.match_address !== want.match_address) begin
               note_mismatch("match_address", want.match_address, rsp_payload.match_address);
            end
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      case (index)
         CSR_SIG_BYTES_LOW: begin
            search_cfg.sig_bytes_low = value;
         end
         CSR_SIG_BYTES_HIGH: begin
            search_cfg.sig_bytes_high = value;
         end
         CSR_CARE_MASK: begin
            search_cfg.care_mask = value[CARE_BITS-1:0];
         end
         CSR_SIG_LENGTH: begin
            search_cfg.sig_length = value[LEN_BITS-1:0];
         end
         CSR_REGION_BASE: begin
            search_cfg.region_base = value;
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_config(input logic [63:0] sig_low, input logic [63:0] sig_high,
                             input logic [15:0] care, input logic [4:0] len,
                             input logic [63:0] base);
      write_register(CSR_SIG_BYTES_LOW, sig_low);
      write_register(CSR_SIG_BYTES_HIGH, sig_high);
      write_register(CSR_CARE_MASK, {48'd0, care});
      write_register(CSR_SIG_LENGTH, {59'd0, len});
      write_register(CSR_REGION_BASE, base);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      req_type item;
      item.data_byte = value;
      item.last_byte = is_last;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predict_search_step(item);
   endtask

   task automatic drain_results();
      int waited;
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         note_mismatch("missing results", 64'(expected_results.size()), '0);
         expected_results.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic test_reset_state();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain_results();
   endtask

   task automatic test_wildcard_matches();
      set_config(64'h1122_3344_DDCC_BBAA, 64'hFFEE_DDCC_BBAA_9988, 16'hFFFB, 5'd4,
                 64'hFFFF_FFFF_FFFF_FFFE);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'hDD, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'hDD, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b0);
      send_byte(8'hDD, 1'b1);
      drain_results();
   endtask

   task automatic test_length_limits();
      set_config(64'h0000_0000_0000_00C3, 64'h0, 16'h0000, 5'd1, 64'h0000_0000_0000_1000);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);
      drain_results();
      set_config(64'h0, 64'h0, 16'hFFFF, 5'd31, 64'h0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      drain_results();
   endtask

   task automatic pick_config(input int phase);
      logic [15:0] care;
      logic [4:0]  len;
      logic [63:0] base;
      case (phase % 8)
         0: len = 5'd1;
         1: len = 5'd16;
         2: len = (phase < 8) ? 5'd0 : 5'(SIG_MAX);
         3: len = 5'($urandom_range(17, 31));
         default: len = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(3))
         0: care = 16'hFFFF;
         1: care = 16'($urandom);
         2: care = 16'($urandom) | 16'($urandom);
         default: care = (phase == 12) ? 16'h0000 : 16'($urandom) | 16'($urandom);
      endcase
      case (phase % 5)
         0: base = '1;
         1: base = '0;
         default: base = {$urandom, $urandom};
      endcase
      set_config({$urandom, $urandom}, {$urandom, $urandom}, care, len, base);
   endtask

   task automatic send_region(output int region_len);
      logic [7:0] region_bytes [0:63];
      int         mode;
      int         slen;
      int         start;
      int         broken_pos;
      region_len = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
      mode = $urandom_range(99);
      slen = (search_cfg.sig_length > SIG_MAX) ? SIG_MAX : int'(search_cfg.sig_length);
      for (int k = 0; k < region_len; k++) begin
         if (mode < 85 && $urandom_range(1) == 1) begin
            region_bytes[k] = signature_byte($urandom_range(SIG_MAX - 1));
         end else begin
            region_bytes[k] = 8'($urandom);
         end
      end
      if (mode < 70 && slen > 0 && slen <= region_len) begin
         start = $urandom_range(region_len - slen);
         for (int j = 0; j < slen; j++) begin
            region_bytes[start+j] = search_cfg.care_mask[j] ? signature_byte(j) : 8'($urandom);
         end
         if ($urandom_range(4) == 0) begin
            broken_pos = start + $urandom_range(slen - 1);
            region_bytes[broken_pos] = ~region_bytes[broken_pos];
         end
      end
      for (int k = 0; k < region_len; k++) begin
         send_byte(region_bytes[k], k == region_len - 1);
      end
   endtask

   task automatic test_random_search();
      int sent;
      int region_len;
      for (int phase = 0; phase < 16; phase++) begin
         calm = (phase == 6 || phase == 7);
         pick_config(phase);
         sent = 0;
         while (sent < 125) begin
            send_region(region_len);
            sent += region_len;
         end
         drain_results();
      end
      calm = 1'b0;
   endtask

   initial begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         recent_bytes[k] = 8'h00;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_wildcard_matches();
      test_length_limits();
      test_random_search();
      drain_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_wildcard_byte_signature_search_top passed");
      end else begin
         $display("tb_wildcard_byte_signature_search_top failed");
      end
      $finish;
   end

endmodule
